@@ hw/rtl/csi_pkg.sv @@
// Shared constants and types for the checkerboard site index core.
// No dependencies; every other file of the block imports this package.
package csi_pkg;

    localparam int CSI_COORD_BITS = 12;
    localparam int CSI_SIZE_BITS = 8;
    localparam int CSI_INDEX_BITS = 32;
    localparam int CSI_CFG_INDEX_BITS = 4;

    // Remainder steps done in each stage of the modulo pipeline.
    localparam int CSI_DIV_STEPS = 4;

    // Stages after the modulo pipeline: three multiply stages and the output add.
    localparam int CSI_COMBINE_STAGES = 4;

    localparam int CSI_RESET_SIZE = 8;

    typedef enum logic [CSI_CFG_INDEX_BITS-1:0] {
        CSI_REG_SIZE_X = 4'd0,
        CSI_REG_SIZE_Y = 4'd1,
        CSI_REG_SIZE_Z = 4'd2,
        CSI_REG_SIZE_T = 4'd3
    } csi_reg_t;

    // Pipeline control handed from the top level to the datapath modules.
    typedef struct packed {
        logic advance;
    } csi_ctrl_t;

endpackage

@@ hw/rtl/csi_ifs.sv @@
// Channel interfaces of the checkerboard site index core: coordinates in,
// site index out and the configuration write channel. Depends on csi_pkg.
interface csi_coord_if
    import csi_pkg::*;
    #(parameter int COORD_BITS = CSI_COORD_BITS)
    ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [COORD_BITS-1:0] coord_z;
    logic [COORD_BITS-1:0] coord_t;

    modport source (output valid, coord_x, coord_y, coord_z, coord_t, input ready);
    modport sink (input valid, coord_x, coord_y, coord_z, coord_t, output ready);
endinterface

interface csi_index_if
    import csi_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [CSI_INDEX_BITS-1:0] site_index;

    modport source (output valid, site_index, input ready);
    modport sink (input valid, site_index, output ready);
endinterface

interface csi_cfg_if
    import csi_pkg::*;
    #(parameter int SIZE_BITS = CSI_SIZE_BITS)
    ();
    logic                          valid;
    logic                          ready;
    logic [CSI_CFG_INDEX_BITS-1:0] index;
    logic [SIZE_BITS:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/csi_mod_lane.sv @@
// One lane of the pipelined modulo unit: restoring remainder, four bits
// per stage. Depends on csi_pkg.
module csi_mod_lane
    import csi_pkg::*;
#(
    parameter int COORD_BITS = CSI_COORD_BITS,
    parameter int SIZE_BITS  = CSI_SIZE_BITS
)
(
    input  logic                  clk,
    input  csi_ctrl_t             ctrl,
    input  logic [COORD_BITS-1:0] dividend,
    input  logic [SIZE_BITS:0]    divisor,
    output logic [SIZE_BITS:0]    remainder
);

    localparam int L      = SIZE_BITS + 1;
    localparam int STAGES = (COORD_BITS + CSI_DIV_STEPS - 1) / CSI_DIV_STEPS;
    localparam int PADW   = STAGES * CSI_DIV_STEPS;
    localparam int SW     = L + PADW;

    // Each stage holds {partial remainder, dividend bits still to shift in}.
    logic [SW-1:0] st_reg [STAGES];
    logic [SW-1:0] st_next [STAGES];

    function automatic logic [SW-1:0] mod_steps(input logic [SW-1:0] st,
                                                input logic [L-1:0] d);
        logic [L-1:0]    rem;
        logic [PADW-1:0] dvd;
        logic [L:0]      trial;
        rem = st[SW-1:PADW];
        dvd = st[PADW-1:0];
        for (int i = 0; i < CSI_DIV_STEPS; i++) begin
            trial = {rem, dvd[PADW-1]};
            if (trial >= {1'b0, d}) begin
                trial = trial - {1'b0, d};
            end
            rem = trial[L-1:0];
            dvd = {dvd[PADW-2:0], 1'b0};
        end
        return {rem, dvd};
    endfunction

    always_comb
    begin
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                st_next[s] = mod_steps({{L{1'b0}}, PADW'(dividend)}, divisor);
            end else begin
                st_next[s] = mod_steps(st_reg[s-1], divisor);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance) begin
            for (int s = 0; s < STAGES; s++) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // A zero extent gives a zero local coordinate. The user must see that
    // the divisor holds steady while words are in flight (not enforced).
    assign remainder = (divisor == '0) ? '0 : st_reg[STAGES-1][SW-1:PADW];

endmodule

@@ hw/rtl/csi_combine.sv @@
// Multiply-add stages that turn the reduced coordinates and parity into the
// checkerboard index. Depends on csi_pkg.
module csi_combine
    import csi_pkg::*;
#(
    parameter int SIZE_BITS = CSI_SIZE_BITS
)
(
    input  logic                      clk,
    input  csi_ctrl_t                 ctrl,
    input  logic [SIZE_BITS:0]        cx,
    input  logic [SIZE_BITS:0]        cy,
    input  logic [SIZE_BITS:0]        cz,
    input  logic [SIZE_BITS:0]        ct,
    input  logic                      parity,
    input  logic [SIZE_BITS-1:0]      hx,
    input  logic [SIZE_BITS:0]        ly,
    input  logic [SIZE_BITS:0]        lz,
    input  logic [SIZE_BITS:0]        lt,
    output logic [CSI_INDEX_BITS-1:0] site_index
);

    localparam int L    = SIZE_BITS + 1;
    localparam int P1W  = 2 * L;
    localparam int S1W  = 2 * L + 1;
    localparam int P2W  = 3 * L + 1;
    localparam int S2W  = 3 * L + 2;
    localparam int LEXW = S2W + SIZE_BITS;
    localparam int VAW  = SIZE_BITS + L;
    localparam int VBW  = 2 * L;
    localparam int VW   = VAW + VBW;
    localparam int W    = CSI_INDEX_BITS;

    logic [P1W-1:0] p1_reg;
    logic [L-1:0]   cx1_reg, cy1_reg, cz1_reg, cx2_reg, cy2_reg;
    logic           par1_reg, par2_reg;
    logic [VAW-1:0] va_reg;
    logic [VBW-1:0] vb_reg;
    logic [P2W-1:0] p2_reg;
    logic [W-1:0]   vol_reg;
    logic [W-1:0]   prod_reg;
    logic [W-1:0]   off_reg;
    logic [W-1:0]   site_reg;

    logic [S1W-1:0]  s1;
    logic [S2W-1:0]  s2;
    logic [LEXW-1:0] lex_prod;
    logic [VW-1:0]   vol_full;

    assign s1       = S1W'(p1_reg) + S1W'(cz1_reg);
    assign s2       = S2W'(p2_reg) + S2W'(cy2_reg);
    assign lex_prod = LEXW'(hx) * LEXW'(s2);
    assign vol_full = VW'(va_reg) * VW'(vb_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.advance) begin
            p1_reg   <= P1W'(lz) * P1W'(ct);
            va_reg   <= VAW'(hx) * VAW'(ly);
            vb_reg   <= VBW'(lz) * VBW'(lt);
            cx1_reg  <= cx;
            cy1_reg  <= cy;
            cz1_reg  <= cz;
            par1_reg <= parity;

            p2_reg   <= P2W'(ly) * P2W'(s1);
            vol_reg  <= W'(vol_full);
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            par2_reg <= par1_reg;

            prod_reg <= W'(lex_prod);
            off_reg  <= (par2_reg ? vol_reg : '0) + W'(cx2_reg);

            site_reg <= prod_reg + off_reg;
        end
    end

    assign site_index = site_reg;

endmodule

@@ hw/rtl/checkerboard_site_index_core.sv @@
// Top level of the checkerboard site index core: configuration registers,
// valid pipeline and four modulo lanes feeding the combine stages.
// Depends on csi_pkg, csi_ifs, csi_mod_lane and csi_combine.

// One 4-D coordinate word enters per cycle while the output is not stalled,
// and passes ceil(COORD_BITS/4) + 4 register stages before its checkerboard
// site index is offered: the modulo lanes retire four remainder bits per
// stage, then three multiply stages and an output add follow. Throughput is
// one word per cycle; a stall on the output freezes the whole pipeline. The
// local sizes must be written by the user through the configuration channel
// only while no word is in flight; the block itself does not enforce this.
module checkerboard_site_index_core
    import csi_pkg::*;
#(
    parameter int COORD_BITS = CSI_COORD_BITS,
    parameter int SIZE_BITS  = CSI_SIZE_BITS
)
(
    input logic         clk,
    input logic         rst_n,
    csi_coord_if.sink   coord,
    csi_index_if.source site,
    csi_cfg_if.sink     cfg
);

    localparam int L          = SIZE_BITS + 1;
    localparam int DIV_STAGES = (COORD_BITS + CSI_DIV_STEPS - 1) / CSI_DIV_STEPS;
    localparam int LAT        = DIV_STAGES + CSI_COMBINE_STAGES;

    logic [L-1:0] size_x_reg, size_y_reg, size_z_reg, size_t_reg;
    logic [LAT-1:0]        vld_reg;
    logic [DIV_STAGES-1:0] par_reg;
    csi_ctrl_t             ctrl;
    logic [L-1:0]          cx, cy, cz, ct;
    logic [SIZE_BITS-1:0]  hx;

    assign cfg.ready    = 1'b1;
    assign ctrl.advance = !vld_reg[LAT-1] || site.ready;
    assign coord.ready  = ctrl.advance;
    assign site.valid   = vld_reg[LAT-1];
    assign hx           = size_x_reg[L-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            size_x_reg <= L'(CSI_RESET_SIZE);
            size_y_reg <= L'(CSI_RESET_SIZE);
            size_z_reg <= L'(CSI_RESET_SIZE);
            size_t_reg <= L'(CSI_RESET_SIZE);
        end else if (cfg.valid) begin
            unique case (cfg.index)
                CSI_REG_SIZE_X: size_x_reg <= cfg.data;
                CSI_REG_SIZE_Y: size_y_reg <= cfg.data;
                CSI_REG_SIZE_Z: size_z_reg <= cfg.data;
                CSI_REG_SIZE_T: size_t_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (ctrl.advance) begin
            vld_reg <= {vld_reg[LAT-2:0], coord.valid};
        end
    end

    // Parity rides alongside the modulo lanes.
    always_ff @(posedge clk)
    begin
        if (ctrl.advance) begin
            par_reg[0] <= coord.coord_x[0] ^ coord.coord_y[0]
                        ^ coord.coord_z[0] ^ coord.coord_t[0];
            for (int s = 1; s < DIV_STAGES; s++) begin
                par_reg[s] <= par_reg[s-1];
            end
        end
    end

    csi_mod_lane #(.COORD_BITS(COORD_BITS), .SIZE_BITS(SIZE_BITS)) u_mod_x (
        .clk(clk), .ctrl(ctrl),
        .dividend(coord.coord_x >> 1), .divisor(L'(hx)), .remainder(cx)
    );

    csi_mod_lane #(.COORD_BITS(COORD_BITS), .SIZE_BITS(SIZE_BITS)) u_mod_y (
        .clk(clk), .ctrl(ctrl),
        .dividend(coord.coord_y), .divisor(size_y_reg), .remainder(cy)
    );

    csi_mod_lane #(.COORD_BITS(COORD_BITS), .SIZE_BITS(SIZE_BITS)) u_mod_z (
        .clk(clk), .ctrl(ctrl),
        .dividend(coord.coord_z), .divisor(size_z_reg), .remainder(cz)
    );

    csi_mod_lane #(.COORD_BITS(COORD_BITS), .SIZE_BITS(SIZE_BITS)) u_mod_t (
        .clk(clk), .ctrl(ctrl),
        .dividend(coord.coord_t), .divisor(size_t_reg), .remainder(ct)
    );

    csi_combine #(.SIZE_BITS(SIZE_BITS)) u_combine (
        .clk(clk), .ctrl(ctrl),
        .cx(cx), .cy(cy), .cz(cz), .ct(ct), .parity(par_reg[DIV_STAGES-1]),
        .hx(hx), .ly(size_y_reg), .lz(size_z_reg), .lt(size_t_reg),
        .site_index(site.site_index)
    );

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        site.valid && !site.ready |-> !coord.ready)
        else $error("input accepted while the output word is stalled");

    a_empty_output_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !site.valid |-> coord.ready)
        else $error("input refused with an empty output stage");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        coord.valid && coord.ready |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_cfg_write_x: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.index == CSI_REG_SIZE_X |=> size_x_reg == $past(cfg.data))
        else $error("x size register not updated by its write");
`endif

endmodule
